@@ rtl/core/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, token codes and character constants for the markup token
// scanner: transfer structs, scan modes and the keyword spelling table.
// ----------------------------------------------------------------------------
package mts_pkg;

  // default width of the line counter
  localparam int LINE_BITS_DEF = 16;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // keyword spelled by the identifier matcher
  localparam logic [2:0] KW_LEN = 3'd7;

  // characters the scanner recognizes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  // token kinds
  typedef enum logic [3:0] {
    TK_LBRACE   = 4'd0,
    TK_RBRACE   = 4'd1,
    TK_COLON    = 4'd2,
    TK_EQUAL    = 4'd3,
    TK_SEMI     = 4'd4,
    TK_LBRACKET = 4'd5,
    TK_RBRACKET = 4'd6,
    TK_AT       = 4'd7,
    TK_COMMENT  = 4'd8,
    TK_STRING   = 4'd9,
    TK_IDENT    = 4'd10,
    TK_INHERIT  = 4'd11,
    TK_EOF      = 4'd12,
    TK_ILLEGAL  = 4'd13
  } token_kind_t;

  // scanner modes
  typedef enum logic [3:0] {
    SM_IDLE  = 4'd0,
    SM_SLASH = 4'd1,
    SM_LCOM  = 4'd2,
    SM_BCOM  = 4'd3,
    SM_BSTAR = 4'd4,
    SM_HASH0 = 4'd5,
    SM_HASH  = 4'd6,
    SM_STR   = 4'd7,
    SM_IDENT = 4'd8
  } scan_mode_t;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  // result item
  typedef struct packed {
    token_kind_t token_kind;
    logic [7:0]  literal_byte;
    logic        has_byte;
    logic        token_first;
    logic        token_last;
    logic [15:0] line_number;
    logic        run_last;
  } out_item_t;

  // one queue entry: the results caused by one input byte
  typedef struct packed {
    out_item_t ev0;
    out_item_t ev1;
    logic      two;
  } step_rec_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // keyword spelling, one character per match position
  function automatic logic [7:0] kw_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h69;  // i
      3'd1:    c = 8'h6e;  // n
      3'd2:    c = 8'h68;  // h
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h72;  // r
      3'd5:    c = 8'h69;  // i
      3'd6:    c = 8'h74;  // t
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/mts_front.sv @@
// ----------------------------------------------------------------------------
// mts_front
// Scanner front end: takes one source byte per transfer, runs the scan mode
// machine, keyword matcher and line counter, and packs the up to two token
// events of that byte into one queue entry.
// ----------------------------------------------------------------------------
module mts_front #(
  parameter int LINE_BITS = mts_pkg::LINE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mts_pkg::in_item_t  in_data,
  output logic               push,
  output mts_pkg::step_rec_t push_rec
);
  import mts_pkg::*;

  scan_mode_t           mode_r, mode_nxt;
  logic [2:0]           kwlen_r, kwlen_nxt;
  logic                 kwmis_r, kwmis_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  logic [LINE_BITS+15:0] line_ext;
  logic [15:0]           line16;
  logic                  accept;
  logic [7:0]            b;
  logic                  eoi;

  // between-token decode of the current byte
  logic       id_emit;
  out_item_t  id_ev;
  scan_mode_t id_mode;
  logic       id_bump;
  logic       id_kw;

  // event slots: pre comes before post
  logic      pre_v, post_v, idle_apply, bump, kw_start, kw_feed;
  out_item_t pre_ev, post_ev;
  logic      kw_hit;
  logic      ident_inherit;

  function automatic out_item_t mk_ev(input token_kind_t k, input logic [7:0] ch,
                                      input logic has, input logic first,
                                      input logic last, input logic [15:0] ln);
    out_item_t e;
    e.token_kind   = k;
    e.literal_byte = has ? ch : 8'h00;
    e.has_byte     = has;
    e.token_first  = first;
    e.token_last   = last;
    e.line_number  = ln;
    e.run_last     = 1'b0;
    return e;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic is_ident_more(input logic [7:0] c);
    return is_alpha(c) || ((c >= CH_DIG_0) && (c <= CH_DIG_9)) ||
           (c == CH_UNDER) || (c == CH_DASH);
  endfunction

  assign accept   = in_valid && !in_stall;
  assign b        = in_data.data_byte;
  assign eoi      = in_data.end_of_input || (in_data.data_byte == CH_NUL);
  assign line_ext = {16'd0, line_r};
  assign line16   = line_ext[15:0];

  // keyword matcher compare
  assign kw_hit        = !kwmis_r && (kwlen_r < KW_LEN) && (b == kw_char(kwlen_r));
  assign ident_inherit = !kwmis_r && (kwlen_r == KW_LEN);

  // byte handling between tokens
  always_comb begin
    id_emit = 1'b0;
    id_ev   = mk_ev(TK_ILLEGAL, b, 1'b1, 1'b1, 1'b1, line16);
    id_mode = SM_IDLE;
    id_bump = 1'b0;
    id_kw   = 1'b0;
    unique case (b) inside
      CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: begin
      end
      CH_LF:     id_bump = 1'b1;
      CH_SLASH:  id_mode = SM_SLASH;
      CH_LBRACE: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_LBRACE, b, 1'b1, 1'b1, 1'b1, line16);
      end
      CH_RBRACE: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_RBRACE, b, 1'b1, 1'b1, 1'b1, line16);
      end
      CH_COLON: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_COLON, b, 1'b1, 1'b1, 1'b1, line16);
      end
      CH_EQUAL: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_EQUAL, b, 1'b1, 1'b1, 1'b1, line16);
      end
      CH_SEMI: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_SEMI, b, 1'b1, 1'b1, 1'b1, line16);
      end
      CH_LBRACK: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_LBRACKET, b, 1'b1, 1'b1, 1'b1, line16);
      end
      CH_RBRACK: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_RBRACKET, b, 1'b1, 1'b1, 1'b1, line16);
      end
      CH_AT: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_AT, b, 1'b1, 1'b1, 1'b1, line16);
      end
      CH_HASH: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_COMMENT, b, 1'b0, 1'b1, 1'b0, line16);
        id_mode = SM_HASH0;
      end
      CH_QUOTE: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_STRING, b, 1'b0, 1'b1, 1'b0, line16);
        id_mode = SM_STR;
      end
      [CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_UNDER: begin
        id_emit = 1'b1;
        id_ev   = mk_ev(TK_IDENT, b, 1'b1, 1'b1, 1'b0, line16);
        id_mode = SM_IDENT;
        id_kw   = 1'b1;
      end
      default: id_emit = 1'b1;
    endcase
  end

  // scan mode machine: next state and event slots
  always_comb begin
    mode_nxt   = mode_r;
    kwlen_nxt  = kwlen_r;
    kwmis_nxt  = kwmis_r;
    line_nxt   = line_r;
    pre_v      = 1'b0;
    pre_ev     = mk_ev(TK_ILLEGAL, CH_SLASH, 1'b1, 1'b1, 1'b1, line16);
    post_v     = 1'b0;
    post_ev    = id_ev;
    idle_apply = 1'b0;
    bump       = 1'b0;
    kw_start   = 1'b0;
    kw_feed    = 1'b0;
    if (eoi) begin
      // close any open token, then end of file and back to reset state
      unique case (mode_r)
        SM_SLASH: pre_v = 1'b1;
        SM_HASH0, SM_HASH: begin
          pre_v  = 1'b1;
          pre_ev = mk_ev(TK_COMMENT, b, 1'b0, 1'b0, 1'b1, line16);
        end
        SM_STR: begin
          pre_v  = 1'b1;
          pre_ev = mk_ev(TK_STRING, b, 1'b0, 1'b0, 1'b1, line16);
        end
        SM_IDENT: begin
          pre_v  = 1'b1;
          pre_ev = mk_ev(ident_inherit ? TK_INHERIT : TK_IDENT, b, 1'b0, 1'b0, 1'b1,
                         line16);
        end
        default: begin
        end
      endcase
      post_v    = 1'b1;
      post_ev   = mk_ev(TK_EOF, b, 1'b0, 1'b1, 1'b1, line16);
      mode_nxt  = SM_IDLE;
      kwlen_nxt = '0;
      kwmis_nxt = 1'b0;
      line_nxt  = LINE_BITS'(1);
    end else begin
      unique case (mode_r)
        SM_SLASH: begin
          if (b == CH_SLASH) begin
            mode_nxt = SM_LCOM;
          end else if (b == CH_STAR) begin
            mode_nxt = SM_BCOM;
          end else begin
            // lone slash is illegal, the byte is rescanned between tokens
            pre_v      = 1'b1;
            idle_apply = 1'b1;
          end
        end
        SM_LCOM: begin
          if (b == CH_LF) begin
            bump     = 1'b1;
            mode_nxt = SM_IDLE;
          end
        end
        SM_BCOM: begin
          if (b == CH_STAR) begin
            mode_nxt = SM_BSTAR;
          end else if (b == CH_LF) begin
            bump = 1'b1;
          end
        end
        SM_BSTAR: begin
          if (b == CH_SLASH) begin
            mode_nxt = SM_IDLE;
          end else if (b != CH_STAR) begin
            bump     = (b == CH_LF);
            mode_nxt = SM_BCOM;
          end
        end
        SM_HASH0, SM_HASH: begin
          if ((mode_r == SM_HASH0) && (b == CH_SPACE)) begin
            mode_nxt = SM_HASH;
          end else if (b == CH_LF) begin
            pre_v      = 1'b1;
            pre_ev     = mk_ev(TK_COMMENT, b, 1'b0, 1'b0, 1'b1, line16);
            idle_apply = 1'b1;
          end else begin
            mode_nxt = SM_HASH;
            pre_v    = 1'b1;
            pre_ev   = mk_ev(TK_COMMENT, b, 1'b1, 1'b0, 1'b0, line16);
          end
        end
        SM_STR: begin
          pre_v = 1'b1;
          if (b == CH_QUOTE) begin
            pre_ev   = mk_ev(TK_STRING, b, 1'b0, 1'b0, 1'b1, line16);
            mode_nxt = SM_IDLE;
          end else begin
            pre_ev = mk_ev(TK_STRING, b, 1'b1, 1'b0, 1'b0, line16);
          end
        end
        SM_IDENT: begin
          pre_v = 1'b1;
          if (is_ident_more(b)) begin
            kw_feed = 1'b1;
            pre_ev  = mk_ev(TK_IDENT, b, 1'b1, 1'b0, 1'b0, line16);
          end else begin
            pre_ev     = mk_ev(ident_inherit ? TK_INHERIT : TK_IDENT, b, 1'b0, 1'b0,
                               1'b1, line16);
            idle_apply = 1'b1;
          end
        end
        default: idle_apply = 1'b1;
      endcase

      // rescan between tokens
      if (idle_apply) begin
        mode_nxt = id_mode;
        bump     = id_bump;
        kw_start = id_kw;
        post_v   = id_emit;
      end

      // keyword matcher update
      if (kw_start) begin
        kwlen_nxt = (b == kw_char(3'd0)) ? 3'd1 : 3'd0;
        kwmis_nxt = (b != kw_char(3'd0));
      end else if (kw_feed) begin
        if (kw_hit) begin
          kwlen_nxt = kwlen_r + 3'd1;
        end else begin
          kwmis_nxt = 1'b1;
        end
      end

      // saturating line count
      if (bump && !(&line_r)) begin
        line_nxt = line_r + LINE_BITS'(1);
      end
    end
  end

  // pack the events of this byte into one queue entry
  always_comb begin
    push_rec = '0;
    if (pre_v) begin
      push_rec.ev0          = pre_ev;
      push_rec.ev1          = post_ev;
      push_rec.two          = post_v;
      push_rec.ev0.run_last = !post_v;
      push_rec.ev1.run_last = 1'b1;
    end else begin
      push_rec.ev0          = post_ev;
      push_rec.ev1          = post_ev;
      push_rec.two          = 1'b0;
      push_rec.ev0.run_last = 1'b1;
      push_rec.ev1.run_last = 1'b1;
    end
  end

  assign push = accept && (pre_v || post_v);

  // scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= SM_IDLE;
      kwlen_r <= '0;
      kwmis_r <= 1'b0;
      line_r  <= LINE_BITS'(1);
    end else if (accept) begin
      mode_r  <= mode_nxt;
      kwlen_r <= kwlen_nxt;
      kwmis_r <= kwmis_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

@@ rtl/core/mts_queue.sv @@
// ----------------------------------------------------------------------------
// mts_queue
// Short first-in first-out queue of per-byte event entries between the
// scanner front end and the output sequencer.
// ----------------------------------------------------------------------------
module mts_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mts_pkg::step_rec_t  push_rec,
  input  logic                pop,
  output mts_pkg::step_rec_t  head_rec,
  output mts_pkg::q_status_t  status
);
  import mts_pkg::*;

  step_rec_t         entry_r [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_rec     = entry_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QIDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QIDX_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/mts_back.sv @@
// ----------------------------------------------------------------------------
// mts_back
// Output sequencer: takes queue entries and presents their events one per
// transfer from an output register, holding a second event aside.
// ----------------------------------------------------------------------------
module mts_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mts_pkg::step_rec_t  head_rec,
  input  mts_pkg::q_status_t  status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mts_pkg::out_item_t  out_data
);
  import mts_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      sec_valid_r;
  out_item_t sec_r;
  logic      load;

  assign load      = !out_valid_r || !out_stall;
  assign pop       = load && !sec_valid_r && !status.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // output register and held second event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (load) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else begin
        out_valid_r <= !status.empty;
        sec_valid_r <= !status.empty && head_rec.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid_r) begin
        out_data_r <= sec_r;
      end else begin
        out_data_r <= head_rec.ev0;
        sec_r      <= head_rec.ev1;
      end
    end
  end

endmodule

@@ rtl/core/markup_token_scanner.sv @@
// ----------------------------------------------------------------------------
// markup_token_scanner
// Streaming tokenizer for a small markup language: one source byte in, token
// events out, split into a scanner front end, a queue and an output stage.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one source byte (or an end mark) per
//   transfer; out_valid/out_stall/out_data carry one token event per
//   transfer, with run_last set on the last event caused by a byte.
//   A byte gives zero, one or two events. Bytes that give none (whitespace,
//   comment text) still take a transfer each. An event passes from its
//   byte's transfer through a queue entry and the output register to
//   out_valid; a byte's second event is held aside and follows the first.
//   Throughput: one byte per cycle while in_stall is low, bounded by the
//   output stage at one event per cycle while out_stall is low, so bytes
//   giving two events use it twice; a four-entry queue absorbs short bursts.
//   in_stall is high while the queue is full. When the receiver holds
//   out_stall, the output register keeps its event and the queue fills,
//   then the input stalls.
//   Reset (rst_n low, synchronous) empties queue and output, returns the
//   scanner to between-token state and sets the line count to one.
//   End of input (end flag or a zero byte) closes any open token, emits end
//   of file, returns the scanner to that same state and resets the line count.
// ----------------------------------------------------------------------------
module markup_token_scanner #(
  parameter int LINE_BITS = mts_pkg::LINE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mts_pkg::out_item_t out_data
);
  import mts_pkg::*;

  logic      push;
  step_rec_t push_rec;
  logic      pop;
  step_rec_t head_rec;
  q_status_t status;

  assign in_stall = status.full;

  // scanner front end
  mts_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_rec (push_rec)
  );

  // event queue
  mts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .status   (status)
  );

  // output sequencer
  mts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_rec  (head_rec),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
